// ----- rtl/core/kct_pkg.sv -----
// Shared widths, status codes and control types of the keyed count table.
package kct_pkg;

	// Field widths
	localparam int KEY_W    = 16;
	localparam int AMT_W    = 32;
	localparam int CNT_W    = 31;
	localparam int STATUS_W = 3;

	// Default geometry
	localparam int ENTRIES_DEF  = 32;
	localparam int KEY_BITS_DEF = 16;

	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [CNT_W-1:0]    count_t;

	// Result status codes
	localparam status_t STS_UPDATED   = 3'd0;
	localparam status_t STS_INSERTED  = 3'd1;
	localparam status_t STS_REMOVED   = 3'd2;
	localparam status_t STS_EXCESS    = 3'd3;
	localparam status_t STS_NOT_FOUND = 3'd4;
	localparam status_t STS_INVALID   = 3'd5;
	localparam status_t STS_IGNORED   = 3'd6;
	localparam status_t STS_FULL      = 3'd7;

	// Operation codes
	localparam logic OP_ADD    = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic capture;
		logic lookup;
		logic commit;
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic out_free;
	} sts_t;

endpackage

// ----- rtl/core/kct_ctrl.sv -----
// Request sequencer: capture, lookup and commit of one request at a time.
module kct_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  kct_pkg::sts_t sts,
	output kct_pkg::cmd_t cmd
);
	import kct_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_LOOK = 2'd1;
	localparam logic [1:0] S_UPD  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       in_fire;
	logic       commit;

	// Take a new beat when idle or in the cycle the previous one commits
	assign commit   = (state_q == S_UPD) && sts.out_free;
	assign in_ready = (state_q == S_IDLE) || commit;
	assign in_fire  = in_valid && in_ready;

	assign cmd.capture = in_fire;
	assign cmd.lookup  = (state_q == S_LOOK);
	assign cmd.commit  = commit;

	// Advance the sequence
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_fire) state_d = S_LOOK;
			end
			S_LOOK: begin
				state_d = S_UPD;
			end
			S_UPD: begin
				if (commit) state_d = in_fire ? S_LOOK : S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- rtl/core/kct_dpath.sv -----
// Table storage, key match, count arithmetic and result register.
module kct_dpath #(
	parameter int ENTRIES  = kct_pkg::ENTRIES_DEF,
	parameter int KEY_BITS = kct_pkg::KEY_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  kct_pkg::cmd_t               cmd,
	output kct_pkg::sts_t               sts,
	input  logic                        operation,
	input  logic [kct_pkg::KEY_W-1:0]   key_id,
	input  logic [kct_pkg::AMT_W-1:0]   amount,
	input  logic                        out_ready,
	output logic                        out_valid,
	output logic [kct_pkg::STATUS_W-1:0] status,
	output logic [kct_pkg::CNT_W-1:0]   count_after
);
	import kct_pkg::*;

	// Stored key width: only the low KEY_BITS of the key field take part
	localparam int KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
	localparam int IW = $clog2(ENTRIES);

	// Captured request
	logic             req_op_q;
	logic [KW-1:0]    req_key_q;
	logic [AMT_W-1:0] req_amt_q;

	// Table: keys and valid bits in flops, counts in a memory
	logic [KW-1:0]    key_q [ENTRIES];
	logic [ENTRIES-1:0] valid_q;
	count_t           cnt_mem [ENTRIES];

	// Lookup results
	logic [ENTRIES-1:0] match;
	logic             hit;
	logic             has_free;
	logic [IW-1:0]    hit_idx;
	logic [IW-1:0]    free_idx;
	logic             hit_q;
	logic             has_free_q;
	logic [IW-1:0]    slot_q;
	count_t           cnt_rd_q;

	// Update results
	count_t           amt_c;
	logic             key_zero;
	logic             amt_bad;
	logic [CNT_W:0]   sum;
	count_t           sum_sat;
	count_t           diff;
	status_t          res_status;
	count_t           res_count;
	logic             wr_cnt;
	logic             wr_ins;
	logic             wr_free;

	// Output register
	logic             out_valid_q;
	status_t          status_q;
	count_t           count_q;

	// Hold the accepted request
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_op_q  <= operation;
			req_key_q <= key_id[KW-1:0];
			req_amt_q <= amount;
		end
	end

	// Compare every valid entry against the key
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			match[i] = valid_q[i] && (key_q[i] == req_key_q);
		end
	end

	// Pick the matching slot and the lowest free slot
	always_comb begin
		hit      = 1'b0;
		has_free = 1'b0;
		hit_idx  = '0;
		free_idx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit     = 1'b1;
				hit_idx = IW'(i);
			end
			if (!valid_q[i]) begin
				has_free = 1'b1;
				free_idx = IW'(i);
			end
		end
	end

	// Register the lookup and read the count of the chosen slot
	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			hit_q      <= hit;
			has_free_q <= has_free;
			slot_q     <= hit ? hit_idx : free_idx;
			cnt_rd_q   <= cnt_mem[hit ? hit_idx : free_idx];
		end
	end

	// Count arithmetic
	assign amt_c    = req_amt_q[CNT_W-1:0];
	assign key_zero = (req_key_q == '0);
	assign amt_bad  = (req_amt_q == '0) || req_amt_q[AMT_W-1];
	assign sum      = {1'b0, cnt_rd_q} + {1'b0, amt_c};
	assign sum_sat  = sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
	assign diff     = cnt_rd_q - amt_c;

	// Decide status, count and table writes
	always_comb begin
		res_status = STS_UPDATED;
		res_count  = '0;
		wr_cnt     = 1'b0;
		wr_ins     = 1'b0;
		wr_free    = 1'b0;
		if (key_zero) begin
			res_status = STS_INVALID;
		end else if (amt_bad) begin
			res_status = STS_IGNORED;
			res_count  = hit_q ? cnt_rd_q : '0;
		end else if (req_op_q == OP_ADD) begin
			if (hit_q) begin
				res_status = STS_UPDATED;
				res_count  = sum_sat;
				wr_cnt     = 1'b1;
			end else if (has_free_q) begin
				res_status = STS_INSERTED;
				res_count  = amt_c;
				wr_cnt     = 1'b1;
				wr_ins     = 1'b1;
			end else begin
				res_status = STS_FULL;
			end
		end else begin
			if (!hit_q) begin
				res_status = STS_NOT_FOUND;
			end else if (cnt_rd_q > amt_c) begin
				res_status = STS_UPDATED;
				res_count  = diff;
				wr_cnt     = 1'b1;
			end else begin
				res_status = (cnt_rd_q < amt_c) ? STS_EXCESS : STS_REMOVED;
				wr_free    = 1'b1;
			end
		end
	end

	// Write the count memory and the key store
	always_ff @(posedge clk) begin
		if (cmd.commit && wr_cnt) begin
			cnt_mem[slot_q] <= res_count;
		end
		if (cmd.commit && wr_ins) begin
			key_q[slot_q] <= req_key_q;
		end
	end

	// Set valid on insert, drop it when the count runs out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.commit && (wr_ins || wr_free)) begin
			valid_q[slot_q] <= wr_ins;
		end
	end

	// Result register: load on commit, drop once the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q <= res_status;
			count_q  <= res_count;
		end
	end

	assign sts.out_free = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign count_after  = count_q;

	// A commit never overwrites a result that is still waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid_q || out_ready))
		else $error("result overwritten before it was taken");

	// Keys in the table are unique
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.lookup |-> $onehot0(match))
		else $error("key held in more than one slot");

	// An insert leaves its slot valid
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && wr_ins) |=> valid_q[$past(slot_q)])
		else $error("inserted slot not valid");

	// Results without an entry carry a zero count
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && (res_status == STS_REMOVED || res_status == STS_EXCESS ||
			res_status == STS_NOT_FOUND || res_status == STS_INVALID ||
			res_status == STS_FULL)) |-> (res_count == '0))
		else $error("nonzero count for absent key");

endmodule

// ----- rtl/core/keyed_count_table_unit.sv -----
// Top level of the keyed count table: controller plus table datapath.
//
//  channel | signals                              | handshake
//  --------+--------------------------------------+----------------------
//  request | operation, key_id, amount            | in_valid / in_ready
//  result  | status, count_after                  | out_valid / out_ready
//
// A request passes a lookup state (parallel key compare, priority pick and count
// memory read) and then an update state (count update and table write).
// The read-modify-write of the matched slot keeps requests from overlapping; a
// back-to-back request is accepted as the previous one commits, once the result register drains.
// arst_n clears all valid bits and the control state; the table is empty.
// A stalled result holds the update stage, and with it new requests.
module keyed_count_table_unit #(
	parameter int ENTRIES  = kct_pkg::ENTRIES_DEF,
	parameter int KEY_BITS = kct_pkg::KEY_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         operation,
	input  logic [kct_pkg::KEY_W-1:0]    key_id,
	input  logic [kct_pkg::AMT_W-1:0]    amount,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [kct_pkg::STATUS_W-1:0] status,
	output logic [kct_pkg::CNT_W-1:0]    count_after
);
	import kct_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Sequence the requests
	kct_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Hold the table and compute results
	kct_dpath #(
		.ENTRIES  (ENTRIES),
		.KEY_BITS (KEY_BITS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.operation   (operation),
		.key_id      (key_id),
		.amount      (amount),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.status      (status),
		.count_after (count_after)
	);

endmodule

// ----- test/tb_keyed_count_table_unit.sv -----
// Testbench for keyed_count_table_unit: directed and random requests against a table predictor.
`timescale 1ns / 100ps

module tb_keyed_count_table_unit;
	import kct_pkg::*;

	localparam int ENTRIES    = ENTRIES_DEF;
	localparam int N_RANDOM   = 1500;
	localparam int QUIET_FROM = 1300;
	localparam int POOL_MAX   = 64;
	localparam int HOLD_AT    = 200;
	localparam int HOLD_LEN   = 150;
	localparam int CYCLE_LIMIT = 200000;
	localparam count_t COUNT_MAX = '1;

	typedef struct packed {
		status_t st;
		count_t  cnt;
	} result_t;

	typedef struct packed {
		logic             op;
		logic [KEY_W-1:0] key;
		logic [AMT_W-1:0] amt;
		logic             typed;
		status_t          st;
		count_t           cnt;
	} req_row_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic                operation;
	logic [KEY_W-1:0]    key_id;
	logic [AMT_W-1:0]    amount;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [CNT_W-1:0]    count_after;

	// Predicted table contents
	logic [KEY_W-1:0] slot_key [ENTRIES];
	count_t           slot_cnt [ENTRIES];
	logic             slot_used [ENTRIES];

	result_t pending_results[$];
	logic [KEY_W-1:0] key_pool [POOL_MAX];
	int accepted;
	int mismatches = 0;
	int cycles = 0;
	int rx_stall = 0;
	logic quiet;
	logic long_hold;

	// Hand-checked opening requests; typed rows carry their result
	localparam int N_DIRECTED = 22;
	req_row_t dir_rows [N_DIRECTED] = '{
		'{OP_REMOVE, 16'h0005, 32'd1,          1'b1, STS_NOT_FOUND, 31'd0},
		'{OP_ADD,    16'h0000, 32'd10,         1'b1, STS_INVALID,   31'd0},
		'{OP_ADD,    16'h0000, 32'd0,          1'b1, STS_INVALID,   31'd0},
		'{OP_REMOVE, 16'h0000, 32'hFFFF_FFFF,  1'b1, STS_INVALID,   31'd0},
		'{OP_ADD,    16'h0001, 32'd0,          1'b1, STS_IGNORED,   31'd0},
		'{OP_ADD,    16'h0001, 32'h8000_0000,  1'b1, STS_IGNORED,   31'd0},
		'{OP_ADD,    16'hFFFF, 32'h7FFF_FFFF,  1'b1, STS_INSERTED,  31'h7FFF_FFFF},
		'{OP_ADD,    16'hFFFF, 32'd1,          1'b1, STS_UPDATED,   31'h7FFF_FFFF},
		'{OP_ADD,    16'hFFFF, 32'h7FFF_FFFF,  1'b1, STS_UPDATED,   31'h7FFF_FFFF},
		'{OP_REMOVE, 16'hFFFF, 32'hFFFF_FFFF,  1'b1, STS_IGNORED,   31'h7FFF_FFFF},
		'{OP_REMOVE, 16'hFFFF, 32'd1,          1'b1, STS_UPDATED,   31'h7FFF_FFFE},
		'{OP_REMOVE, 16'hFFFF, 32'h7FFF_FFFE,  1'b1, STS_REMOVED,   31'd0},
		'{OP_ADD,    16'h0001, 32'd1,          1'b1, STS_INSERTED,  31'd1},
		'{OP_ADD,    16'h8000, 32'd100,        1'b1, STS_INSERTED,  31'd100},
		'{OP_ADD,    16'h0001, 32'd41,         1'b1, STS_UPDATED,   31'd42},
		'{OP_REMOVE, 16'h0001, 32'd43,         1'b1, STS_EXCESS,    31'd0},
		'{OP_ADD,    16'h5A5A, 32'd3,          1'b1, STS_INSERTED,  31'd3},
		'{OP_REMOVE, 16'h8000, 32'h7FFF_FFFF,  1'b1, STS_EXCESS,    31'd0},
		'{OP_REMOVE, 16'h8000, 32'd1,          1'b1, STS_NOT_FOUND, 31'd0},
		'{OP_ADD,    16'h5A5A, 32'h1234_5678,  1'b1, STS_UPDATED,   31'h1234_567B},
		'{OP_ADD,    16'h00FF, 32'h2AAA_AAAA,  1'b0, STS_UPDATED,   31'd0},
		'{OP_REMOVE, 16'h5A5A, 32'h1234_567B,  1'b0, STS_UPDATED,   31'd0}
	};

	keyed_count_table_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.operation  (operation),
		.key_id     (key_id),
		.amount     (amount),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.count_after(count_after)
	);

	// Free-running clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Locate a live slot holding the key, -1 when absent
	function automatic int find_slot(input logic [KEY_W-1:0] key);
		int hit;
		hit = -1;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (slot_used[i] && slot_key[i] == key)
				hit = i;
		end
		return hit;
	endfunction

	// Apply one request to the predicted table and return its result
	function automatic result_t apply_request(input logic op, input logic [KEY_W-1:0] key,
			input logic [AMT_W-1:0] amt);
		result_t r;
		int hit;
		int free_slot;
		logic [CNT_W:0] sum;
		r.st = STS_IGNORED;
		r.cnt = '0;
		if (key == '0) begin
			r.st = STS_INVALID;
		end else begin
			hit = find_slot(key);
			free_slot = -1;
			for (int i = ENTRIES - 1; i >= 0; i--) begin
				if (!slot_used[i])
					free_slot = i;
			end
			if (amt == '0 || amt[AMT_W-1]) begin
				r.st = STS_IGNORED;
				if (hit >= 0)
					r.cnt = slot_cnt[hit];
			end else if (op == OP_ADD) begin
				if (hit >= 0) begin
					// saturate at the largest count
					sum = {1'b0, slot_cnt[hit]} + {1'b0, amt[CNT_W-1:0]};
					slot_cnt[hit] = sum[CNT_W] ? COUNT_MAX : sum[CNT_W-1:0];
					r.cnt = slot_cnt[hit];
					r.st = STS_UPDATED;
				end else if (free_slot >= 0) begin
					slot_used[free_slot] = 1'b1;
					slot_key[free_slot] = key;
					slot_cnt[free_slot] = amt[CNT_W-1:0];
					r.cnt = amt[CNT_W-1:0];
					r.st = STS_INSERTED;
				end else begin
					r.st = STS_FULL;
				end
			end else begin
				if (hit < 0) begin
					r.st = STS_NOT_FOUND;
				end else if (slot_cnt[hit] > amt[CNT_W-1:0]) begin
					slot_cnt[hit] = slot_cnt[hit] - amt[CNT_W-1:0];
					r.cnt = slot_cnt[hit];
					r.st = STS_UPDATED;
				end else begin
					r.st = (slot_cnt[hit] < amt[CNT_W-1:0]) ? STS_EXCESS : STS_REMOVED;
					slot_used[hit] = 1'b0;
				end
			end
		end
		return r;
	endfunction

	// Pick an amount; removes often hit the held count exactly or by one over
	function automatic logic [AMT_W-1:0] pick_amount(input logic op, input logic [KEY_W-1:0] key);
		int sel;
		int hit;
		hit = find_slot(key);
		sel = $urandom_range(0, 15);
		if (op == OP_REMOVE && hit >= 0 && sel < 4)
			return {1'b0, slot_cnt[hit]} + ((sel == 3) ? 32'd1 : 32'd0);
		case (sel)
			4:       return '0;
			5:       return 32'h8000_0000 | $urandom;
			6:       return $urandom;
			7:       return 32'h7FFF_0000 | $urandom_range(0, 65535);
			default: return $urandom_range(1, 200);
		endcase
	endfunction

	// Offer one request beat, hold it until taken, then log its result
	task automatic send_request(input logic op, input logic [KEY_W-1:0] key,
			input logic [AMT_W-1:0] amt, input logic typed, input result_t typed_res);
		result_t r;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		key_id <= key;
		amount <= amt;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		r = apply_request(op, key, amt);
		pending_results.push_back(typed ? typed_res : r);
		accepted++;
	endtask

	// Sender: reset, directed table, random phases, drain
	initial begin
		int psize;
		int add_pct;
		int sel;
		logic op;
		logic [KEY_W-1:0] key;
		logic [AMT_W-1:0] amt;
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = OP_ADD;
		key_id = '0;
		amount = '0;
		quiet = 1'b0;
		accepted = 0;
		for (int i = 0; i < ENTRIES; i++)
			slot_used[i] = 1'b0;
		for (int j = 0; j < POOL_MAX; j++)
			key_pool[j] = KEY_W'($urandom_range(1, 65535));
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++)
			send_request(dir_rows[i].op, dir_rows[i].key, dir_rows[i].amt, dir_rows[i].typed,
				'{dir_rows[i].st, dir_rows[i].cnt});

		// Phases: small pool, fill past capacity, drain, mixed, small pool again
		for (int i = 0; i < N_RANDOM; i++) begin
			case (i / 300)
				0:       begin psize = 8;  add_pct = 60; end
				1:       begin psize = 48; add_pct = 85; end
				2:       begin psize = 48; add_pct = 25; end
				3:       begin psize = 48; add_pct = 55; end
				default: begin psize = 16; add_pct = 50; end
			endcase
			if (i == QUIET_FROM)
				quiet <= 1'b1;
			op = ($urandom_range(0, 99) < add_pct) ? OP_ADD : OP_REMOVE;
			sel = $urandom_range(0, 19);
			if (sel == 0)
				key = KEY_W'($urandom_range(0, 65535));
			else if (sel == 1)
				key = '0;
			else
				key = key_pool[$urandom_range(0, psize - 1)];
			amt = pick_amount(op, key);
			send_request(op, key, amt, 1'b0, '0);
		end
		in_valid <= 1'b0;

		// Wait out every pending result, then let the bench idle before the verdict
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("[keyed_count_table_unit] OK");
		else
			$display("[keyed_count_table_unit] ERROR");
		$finish;
	end

	// Long receiver hold-off so the block backs up and stalls its input
	initial begin
		long_hold = 1'b0;
		wait (accepted >= HOLD_AT);
		@(posedge clk);
		long_hold <= 1'b1;
		repeat (HOLD_LEN) @(posedge clk);
		long_hold <= 1'b0;
	end

	// Receiver: check each result beat, drive ready with random stall bursts
	always @(posedge clk) begin : rx_side
		result_t want;
		if (out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result beat with nothing pending, status %0d count %0d",
					$time, status, count_after);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (status !== want.st) begin
					$display("%0t: status expected %0d actual %0d", $time, want.st, status);
					mismatches++;
				end
				if (count_after !== want.cnt) begin
					$display("%0t: count_after expected %0d actual %0d", $time, want.cnt,
						count_after);
					mismatches++;
				end
			end
		end
		if (!arst_n || long_hold) begin
			out_ready <= 1'b0;
		end else if (rx_stall > 0) begin
			out_ready <= 1'b0;
			rx_stall <= rx_stall - 1;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			out_ready <= 1'b0;
			rx_stall <= $urandom_range(0, 5);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results pending", $time, pending_results.size());
			$display("[keyed_count_table_unit] ERROR");
			$finish;
		end
	end

endmodule

// ----- keyed_count_table_unit.f -----
rtl/core/kct_pkg.sv
rtl/core/kct_ctrl.sv
rtl/core/kct_dpath.sv
rtl/core/keyed_count_table_unit.sv
test/tb_keyed_count_table_unit.sv
